// File: rtl/gmcl_pkg.sv
// ----------------------------------------------------------------------------
// gmcl_pkg
// shared types and constants for the greedy cover lower bound block
// ----------------------------------------------------------------------------
package gmcl_pkg;

    localparam int DEF_ROWS      = 32;
    localparam int DEF_COLS      = 32;
    localparam int DEF_COST_BITS = 16;

    // chain fields are sized for the largest supported row count
    localparam int MAX_IDX_W = 6;
    localparam int MAX_CNT_W = 7;

    localparam int BOUND_W = 21;

    localparam logic [1:0] KIND_ROW  = 2'd0;
    localparam logic [1:0] KIND_COST = 2'd1;
    localparam logic [1:0] KIND_CALC = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT,
        OP_COUNT,
        OP_MARK,
        OP_DEC
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [MAX_IDX_W-1:0]   pick;
    } t_cell_ctrl;

    typedef struct packed {
        logic                   have;
        logic [MAX_CNT_W-1:0]   cnt;
        logic [MAX_IDX_W-1:0]   idx;
    } t_chain;

endpackage

// File: rtl/gmcl_cell.sv
// ----------------------------------------------------------------------------
// gmcl_cell
// one row of the matrix: mask, count, removed and doomed flags, min stage
// ----------------------------------------------------------------------------
module gmcl_cell #(
    parameter int ROWS = gmcl_pkg::DEF_ROWS,
    parameter int COLS = gmcl_pkg::DEF_COLS,
    parameter int IDX  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [COLS-1:0]       i_wr_mask,
    input  gmcl_pkg::t_cell_ctrl  i_ctrl,
    input  logic [COLS-1:0]       i_bcast,
    input  gmcl_pkg::t_chain      i_chain,
    output gmcl_pkg::t_chain      o_chain,
    output logic [COLS-1:0]       o_mask,
    output logic                  o_doomed
);
    import gmcl_pkg::*;

    localparam int CNTW = $clog2(ROWS + 1);
    localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(IDX);

    logic [COLS-1:0] r_mask;
    logic [CNTW-1:0] r_cnt;
    logic            r_removed;
    logic            r_doomed;
    t_chain          r_chain;
    logic            w_adj;
    logic [MAX_CNT_W-1:0] w_cnt_ext;

    assign w_adj     = (r_mask & i_bcast) != '0;
    assign w_cnt_ext = MAX_CNT_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_cnt     <= '0;
            r_removed <= 1'b0;
            r_doomed  <= 1'b0;
            r_chain   <= '0;
        end else begin
            if (i_wr_en) begin
                r_mask <= i_wr_mask;
            end
            unique case (i_ctrl.op)
                OP_INIT: begin
                    r_cnt     <= '0;
                    r_removed <= (r_mask == '0);
                    r_doomed  <= 1'b0;
                end
                OP_COUNT: begin
                    if (w_adj) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                OP_MARK: begin
                    r_doomed <= 1'b0;
                    if (!r_removed && w_adj) begin
                        r_removed <= 1'b1;
                        r_doomed  <= (i_ctrl.pick != MY_IDX);
                    end
                end
                OP_DEC: begin
                    if (!r_removed && w_adj && r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                end
            endcase
            // running minimum handed down the chain, first index wins ties
            if (!r_removed && (!i_chain.have || w_cnt_ext < i_chain.cnt)) begin
                r_chain <= '{have: 1'b1, cnt: w_cnt_ext, idx: MY_IDX};
            end else begin
                r_chain <= i_chain;
            end
        end
    end

    assign o_chain  = r_chain;
    assign o_mask   = r_mask;
    assign o_doomed = r_doomed;

endmodule

// File: rtl/greedy_mis_cover_lower_bound.sv
// ----------------------------------------------------------------------------
// greedy_mis_cover_lower_bound
// lower bound on a unate cover cost by a greedy independent row set
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low
// kind row: writes a row column mask, no result
// kind cost: writes a column cost, no result
// kind calc: raises busy and later gives one result on o_lower_bound
//   with o_valid high for exactly one cycle; busy is already low in that
//   cycle, so the next item can be taken at the edge that ends the strobe
// calc steps: build counts over all rows, then per picked row a min pass
//   down the cell chain, a cost scan over the columns, marking and the
//   neighbor sweep, plus a last min pass that finds no live row, after
//   which the result is registered and strobed
// one broadcast mask per cycle goes into the row cells
// load kinds unused by the block (kind 3) and out-of-range slots do nothing
// reset clears all masks and costs; the receiver cannot stall results
// ----------------------------------------------------------------------------
module greedy_mis_cover_lower_bound #(
    parameter int ROWS      = gmcl_pkg::DEF_ROWS,
    parameter int COLS      = gmcl_pkg::DEF_COLS,
    parameter int COST_BITS = gmcl_pkg::DEF_COST_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_kind,
    input  logic [4:0]                   i_slot,
    input  logic [31:0]                  i_row_columns,
    input  logic [15:0]                  i_column_cost,
    output logic                         o_valid,
    output logic [gmcl_pkg::BOUND_W-1:0] o_lower_bound
);
    import gmcl_pkg::*;

    localparam int IW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KW  = $clog2(ROWS + 1);
    localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_COUNT,
        S_PICK,
        S_COST,
        S_MARK,
        S_DEC
    } t_state;

    t_state                 r_state;
    logic [KW-1:0]          r_k;
    logic [CIW-1:0]         r_c;
    logic [IW-1:0]          r_pick;
    logic [COLS-1:0]        r_pmask;
    logic [COST_BITS-1:0]   r_best;
    logic                   r_found;
    logic [BOUND_W-1:0]     r_total;
    logic                   r_valid;
    logic [BOUND_W-1:0]     r_bound;
    logic [COST_BITS-1:0]   r_cost [COLS];

    logic                   w_accept;
    logic [COLS-1:0]        w_wr_mask;
    logic [COST_BITS-1:0]   w_wr_cost;
    logic [ROWS-1:0]        w_wr_en;
    logic [COLS-1:0]        w_mask [ROWS];
    logic [ROWS-1:0]        w_doomed;
    t_chain                 w_chain [ROWS+1];
    t_cell_ctrl             w_ctrl;
    logic [COLS-1:0]        w_bcast;
    logic [BOUND_W-1:0]     w_best_ext;
    logic [IW-1:0]          w_kidx;

    assign w_accept = start && !busy;
    assign w_kidx   = r_k[IW-1:0];

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            w_wr_mask[c] = (c < 32) ? i_row_columns[c % 32] : 1'b0;
        end
        for (int b = 0; b < COST_BITS; b++) begin
            w_wr_cost[b] = (b < 16) ? i_column_cost[b % 16] : 1'b0;
        end
        for (int b = 0; b < BOUND_W; b++) begin
            w_best_ext[b] = (b < COST_BITS) ? r_best[b % COST_BITS] : 1'b0;
        end
        for (int r = 0; r < ROWS; r++) begin
            w_wr_en[r] = w_accept && (i_kind == KIND_ROW) && (32'(i_slot) == r);
        end
    end

    always_comb begin
        w_ctrl  = '{op: OP_NOP, pick: MAX_IDX_W'(r_pick)};
        w_bcast = w_mask[w_kidx];
        unique case (r_state)
            S_INIT:  w_ctrl.op = OP_INIT;
            S_COUNT: w_ctrl.op = OP_COUNT;
            S_MARK: begin
                w_ctrl.op = OP_MARK;
                w_bcast   = r_pmask;
            end
            S_DEC:   w_ctrl.op = w_doomed[w_kidx] ? OP_DEC : OP_NOP;
            default: w_ctrl.op = OP_NOP;
        endcase
    end

    assign w_chain[0] = '0;

    for (genvar g = 0; g < ROWS; g++) begin : g_cell
        gmcl_cell #(
            .ROWS (ROWS),
            .COLS (COLS),
            .IDX  (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_wr_en[g]),
            .i_wr_mask (w_wr_mask),
            .i_ctrl    (w_ctrl),
            .i_bcast   (w_bcast),
            .i_chain   (w_chain[g]),
            .o_chain   (w_chain[g+1]),
            .o_mask    (w_mask[g]),
            .o_doomed  (w_doomed[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < COLS; c++) begin
                r_cost[c] <= '0;
            end
        end else if (w_accept && i_kind == KIND_COST && 32'(i_slot) < COLS) begin
            r_cost[i_slot[CIW-1:0]] <= w_wr_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_c     <= '0;
            r_pick  <= '0;
            r_found <= 1'b0;
            r_total <= '0;
            r_valid <= 1'b0;
            r_bound <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_kind == KIND_CALC) begin
                        r_state <= S_INIT;
                        r_total <= '0;
                    end
                end
                S_INIT: begin
                    r_k     <= '0;
                    r_state <= S_COUNT;
                end
                S_COUNT: begin
                    if (r_k == KW'(ROWS - 1)) begin
                        r_k     <= '0;
                        r_state <= S_PICK;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_PICK: begin
                    // wait for the min to ripple through every cell
                    if (r_k == KW'(ROWS)) begin
                        r_k <= '0;
                        if (!w_chain[ROWS].have) begin
                            r_valid <= 1'b1;
                            r_bound <= r_total;
                            r_state <= S_IDLE;
                        end else begin
                            r_pick  <= w_chain[ROWS].idx[IW-1:0];
                            r_pmask <= w_mask[w_chain[ROWS].idx[IW-1:0]];
                            r_c     <= '0;
                            r_found <= 1'b0;
                            r_state <= S_COST;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_COST: begin
                    if (r_pmask[r_c] && (!r_found || r_cost[r_c] < r_best)) begin
                        r_best  <= r_cost[r_c];
                        r_found <= 1'b1;
                    end
                    if (r_c == CIW'(COLS - 1)) begin
                        r_state <= S_MARK;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_MARK: begin
                    r_total <= r_total + w_best_ext;
                    r_k     <= '0;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_k == KW'(ROWS - 1)) begin
                        r_k     <= '0;
                        r_state <= S_PICK;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_lower_bound = r_bound;

    a_calc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_CALC) |=> busy)
        else $error("calc item did not raise busy");

    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a calc in flight");

    a_valid_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_doomed_onehot_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> !w_doomed[r_pick])
        else $error("picked row flagged as removed neighbor");

endmodule
